FILE: rtl/khr_pkg.sv
// ----------------------------------------------------------------------------
// khr_pkg: shared types and helpers for k-hop reachability with exclusion
// Item and result layouts, command classes, the sequencer state type and the
// bit-set helpers (one-hop expansion, population count, hop saturation).
// ----------------------------------------------------------------------------
`default_nettype none

package khr_pkg;

  localparam int unsigned NODES       = 16;
  localparam int unsigned HOP_LIMIT   = 63;
  localparam int unsigned ID_W        = 4;
  localparam int unsigned HOP_W       = 6;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } khr_cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } khr_state_e;

  typedef struct packed {
    logic             command;
    logic [ID_W-1:0]  row_index;
    logic [NODES-1:0] row_bits;
    logic [ID_W-1:0]  source_node;
    logic [ID_W-1:0]  avoid_node;
    logic [HOP_W-1:0] source_hops;
    logic [HOP_W-1:0] avoid_hops;
  } khr_in_t;

  typedef struct packed {
    logic [NODES-1:0] result_set;
    logic [CNT_W-1:0] member_count;
  } khr_out_t;

  // Classified entry passed from the front queue to the back sequencer
  typedef struct packed {
    khr_cmd_e         kind;
    logic [ID_W-1:0]  row_index;
    logic [NODES-1:0] row_bits;
    logic [ID_W-1:0]  source_node;
    logic [ID_W-1:0]  avoid_node;
    logic [HOP_W-1:0] source_hops;
    logic [HOP_W-1:0] avoid_hops;
  } khr_entry_t;

  typedef logic [NODES-1:0][NODES-1:0] khr_adj_t;

  // One hop: union of the rows of every node in the set
  function automatic logic [NODES-1:0] expand(logic [NODES-1:0] set, khr_adj_t adj);
    logic [NODES-1:0] next;
    next = '0;
    for (int i = 0; i < NODES; i++) begin
      if (set[i]) begin
        next = next | adj[i];
      end
    end
    return next;
  endfunction

  function automatic logic [CNT_W-1:0] popcount(logic [NODES-1:0] v);
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < NODES; i++) begin
      cnt = cnt + CNT_W'(v[i]);
    end
    return cnt;
  endfunction

  function automatic logic [HOP_W-1:0] sat_hops(logic [HOP_W-1:0] h);
    logic [HOP_W-1:0] lim;
    lim = HOP_W'(HOP_LIMIT);
    return (h > lim) ? lim : h;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/khr_front.sv
// ----------------------------------------------------------------------------
// khr_front: input queue
// Accepts items, classifies them into row writes and queries, saturates hop
// limits and holds them in a short queue until the back sequencer takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module khr_front #(
  parameter int unsigned Depth = khr_pkg::QUEUE_DEPTH
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push,
  output logic                full,
  input  khr_pkg::khr_in_t    in_item_i,
  output logic                q_valid_o,
  output khr_pkg::khr_entry_t q_entry_o,
  input  wire                 q_take_i
);
  import khr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  khr_entry_t            slots_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push;
  logic                  do_pop;
  khr_entry_t            entry;

  // Classify the incoming item
  always_comb begin
    entry.kind        = khr_cmd_e'(in_item_i.command);
    entry.row_index   = in_item_i.row_index;
    entry.row_bits    = in_item_i.row_bits;
    entry.source_node = in_item_i.source_node;
    entry.avoid_node  = in_item_i.avoid_node;
    entry.source_hops = sat_hops(in_item_i.source_hops);
    entry.avoid_hops  = sat_hops(in_item_i.avoid_hops);
  end

  assign full      = (count_q == CntW'(Depth));
  assign q_valid_o = (count_q != '0);
  assign q_entry_o = slots_q[rd_ptr_q];
  assign do_push   = push && !full;
  assign do_pop    = q_take_i && q_valid_o;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/khr_back.sv
// ----------------------------------------------------------------------------
// khr_back: adjacency store and walk sequencer
// Applies row writes, runs the source and avoid walks one hop per cycle in
// parallel and holds the finished result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module khr_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_valid_i,
  input  khr_pkg::khr_entry_t q_entry_i,
  output logic                q_take_o,
  output logic                empty,
  input  wire                 pop,
  output khr_pkg::khr_out_t   out_item_o
);
  import khr_pkg::*;

  khr_state_e       state_q, state_d;
  khr_adj_t         adj_q;
  logic [NODES-1:0] src_front_q, src_reach_q;
  logic [NODES-1:0] avd_front_q, avd_reach_q, avd_bit_q;
  logic [HOP_W-1:0] src_left_q, avd_left_q;
  logic             out_valid_q;
  khr_out_t         out_q;

  logic [NODES-1:0] src_next, avd_next, result;
  logic             walk_done, slot_free;
  logic             do_write, do_start, do_step, do_emit;

  assign src_next  = expand(src_front_q, adj_q);
  assign avd_next  = expand(avd_front_q, adj_q);
  assign walk_done = (src_left_q == '0) && (avd_left_q == '0);
  assign slot_free = !out_valid_q || pop;
  assign result    = src_reach_q & ~(avd_reach_q | avd_bit_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && (q_entry_i.kind == CMD_QUERY)) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done && slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer controls
  always_comb begin
    q_take_o = 1'b0;
    do_step  = 1'b0;
    do_emit  = 1'b0;
    unique case (state_q)
      ST_IDLE: q_take_o = q_valid_i;
      ST_WALK: begin
        do_step = !walk_done;
        do_emit = walk_done && slot_free;
      end
      default: ;
    endcase
  end

  assign do_write = q_take_o && (q_entry_i.kind == CMD_WRITE);
  assign do_start = q_take_o && (q_entry_i.kind == CMD_QUERY);

  // Control state, adjacency and output flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      adj_q       <= '0;
    end else begin
      state_q <= state_d;
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      if (do_write) begin
        adj_q[q_entry_i.row_index] <= q_entry_i.row_bits;
      end
    end
  end

  // Load and advance both walks
  always_ff @(posedge clk_i) begin
    if (do_start) begin
      src_front_q <= NODES'(1) << q_entry_i.source_node;
      src_reach_q <= '0;
      src_left_q  <= q_entry_i.source_hops;
      avd_front_q <= NODES'(1) << q_entry_i.avoid_node;
      avd_bit_q   <= NODES'(1) << q_entry_i.avoid_node;
      avd_reach_q <= '0;
      avd_left_q  <= q_entry_i.avoid_hops;
    end else if (do_step) begin
      if (src_left_q != '0) begin
        src_front_q <= src_next;
        src_reach_q <= src_reach_q | src_next;
        src_left_q  <= src_left_q - HOP_W'(1);
      end
      if (avd_left_q != '0) begin
        avd_front_q <= avd_next;
        avd_reach_q <= avd_reach_q | avd_next;
        avd_left_q  <= avd_left_q - HOP_W'(1);
      end
    end
  end

  // Hold the finished result
  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      out_q.result_set   <= result;
      out_q.member_count <= popcount(result);
    end
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/k_hop_reach_with_exclusion.sv
// ----------------------------------------------------------------------------
// k_hop_reach_with_exclusion: k-hop neighborhood reachability with exclusion
// Loads a 16x16 adjacency matrix row by row and answers queries with the set
// of nodes within source_hops of the source, minus the avoid node and all
// nodes within avoid_hops of it, plus the member count.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   --------  ---------  -----------------  ------------------------------
//   items     in         push / full        in_item_i  (command, row, query)
//   results   out        empty / pop        out_item_o (set, count)
//
// A row write is applied by the sequencer and gives no result.
// A query loads both walks, then the walk loop does one hop of both walks
// per cycle against the register-held matrix, then registers the result.
// Reset clears the matrix (no edges), the queue and the output valid flag.
// The input queue keeps accepting while a query walks or a result waits;
// a waiting result only holds the sequencer when the next query finishes.
//
`default_nettype none

module k_hop_reach_with_exclusion #(
  parameter int unsigned QueueDepth = khr_pkg::QUEUE_DEPTH
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push,
  output logic              full,
  input  khr_pkg::khr_in_t  in_item_i,
  output logic              empty,
  input  wire               pop,
  output khr_pkg::khr_out_t out_item_o
);
  import khr_pkg::*;

  logic       q_valid;
  logic       q_take;
  khr_entry_t q_entry;

  khr_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .q_valid_o (q_valid),
    .q_entry_o (q_entry),
    .q_take_i  (q_take)
  );

  khr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .q_take_o   (q_take),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  // Sequencer only takes entries the queue offers
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take |-> q_valid)
    else $error("sequencer took from an empty queue");

  // A full queue always offers an entry to the sequencer
  a_full_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> q_valid)
    else $error("queue full without an entry on offer");

  // Count matches the set it describes
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.member_count == CNT_W'($countones(out_item_o.result_set))))
    else $error("member count disagrees with result set");

  // A row write never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_take && (q_entry.kind == CMD_WRITE) && empty) |=> empty)
    else $error("row write produced a result");

endmodule

`default_nettype wire
